FILE: hdl/priority_task_scheduler_with_delays_assert.svh
// Assertion macros shared by the scheduler's checker.
// Depends on signals named clk and arst_n in the scope that uses them.
`ifndef PRIORITY_TASK_SCHEDULER_WITH_DELAYS_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_DELAYS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pts_pkg.sv
// Types, codes and default sizes of the task scheduler.
// No dependencies; used by the top level and by its checker.
package pts_pkg;

	localparam int PTS_NUM_PRIORITIES = 8;
	localparam int PTS_NUM_TASKS      = 16;
	localparam int PTS_TICK_BITS      = 32;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_DELAY  = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_SWITCH = 2'd3
	} req_code_t;

	// Where a task is filed; the two delay codes carry the list number in bit 0.
	localparam logic [1:0] PLACE_NONE   = 2'd0;
	localparam logic [1:0] PLACE_READY  = 2'd1;
	localparam logic [1:0] PLACE_DELAY0 = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DET,
		ST_RM_RD,
		ST_RM_CMP,
		ST_RM_SH_RD,
		ST_RM_SH_WR,
		ST_DR_WALK,
		ST_AFTER_DET,
		ST_DI_WALK,
		ST_DI_LINK,
		ST_RI,
		ST_RI_SH_RD,
		ST_RI_SH_WR,
		ST_RI_PUT,
		ST_TK_HEAD,
		ST_TK_END,
		ST_SEL_INIT,
		ST_SEL_SCAN,
		ST_SEL_RD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  task_id;
		logic [7:0]  priority_req;
		logic [31:0] delay_ticks;
	} pts_req_t;

	typedef struct packed {
		logic [3:0]  current_task;
		logic        no_ready_task;
		logic        switch_request;
		logic [31:0] next_unblock_time;
		logic [31:0] tick_now;
	} pts_rsp_t;

endpackage

FILE: hdl/priority_task_scheduler_with_delays.sv
// Fixed-priority round-robin task scheduler with two wake-time ordered delay lists.
// A new beat is taken only in idle, once the previous result strobe is over; the pace is
// set by the single-port ready-list memory and the one-node-per-cycle list walk.
// Reset (arst_n low, asynchronous) empties all lists; the result strobe cannot be stalled.
module priority_task_scheduler_with_delays
	import pts_pkg::*;
#(
	parameter int NUM_PRIORITIES = PTS_NUM_PRIORITIES,
	parameter int NUM_TASKS      = PTS_NUM_TASKS,
	parameter int TICK_BITS      = PTS_TICK_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pts_req_t req,
	output logic     done,
	output pts_rsp_t rsp
);

	// IW indexes a task slot, TW also holds the list end marker (NUM_TASKS).
	localparam int IW = $clog2(NUM_TASKS);
	localparam int TW = $clog2(NUM_TASKS + 1);
	localparam int PW = $clog2(NUM_PRIORITIES);
	localparam logic [TW-1:0] NIL = TW'(NUM_TASKS);

	// Control state.
	state_t          state_q, state_d;
	req_code_t       req_q;
	logic [IW-1:0]   rt_q;
	logic            rv_q;
	logic [PW-1:0]   top_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [TICK_BITS-1:0] unblock_q;
	logic            act_q;
	logic            sw_q;
	logic [TW-1:0]   head_q [2];
	logic [TW-1:0]   cnt_q  [NUM_PRIORITIES];
	logic [TW-1:0]   rcur_q [NUM_PRIORITIES];
	logic [1:0]      place_q [NUM_TASKS];

	// Per-task payload tables; every entry is written before it is read.
	logic [PW-1:0]        prio_q [NUM_TASKS];
	logic [TICK_BITS-1:0] wake_q [NUM_TASKS];
	logic [TW-1:0]        link_q [NUM_TASKS];

	// The ready lists: one row per priority, entries in round-robin order.
	logic [IW-1:0] seq_mem [NUM_PRIORITIES][NUM_TASKS];
	logic [IW-1:0] seq_rd_q;

	// Working registers of the sequencer.
	logic [IW-1:0]        tgt_q;
	logic [PW-1:0]        pnew_q;
	logic [TICK_BITS-1:0] key_q;
	logic [PW-1:0]        p_q;
	logic [PW-1:0]        rp_q;
	logic [TW-1:0]        n_q, c_q, i_q, k_q;
	logic [TW-1:0]        cur_q, prev_q;
	logic                 l_q;

	// Table read ports: each table is read at one address per cycle.
	logic [IW-1:0]        prio_ra;
	logic [PW-1:0]        prio_rd;
	logic [IW-1:0]        wl_ra;
	logic [TICK_BITS-1:0] wake_rd;
	logic [TW-1:0]        link_rd;
	logic [PW-1:0]        cnt_ra;
	logic [TW-1:0]        cnt_rd, rcur_rd;

	// Ready-list memory ports.
	logic          mr_en, mw_en;
	logic [TW-1:0] mr_idx, mw_idx;
	logic [PW-1:0] mr_p, mw_p;
	logic [IW-1:0] mw_d;

	// Derived values used by both the sequencer and the datapath.
	logic                 tid_ok;
	logic [PW-1:0]        pclamp;
	logic [TICK_BITS-1:0] tick_inc;
	logic [1:0]           det_place;
	logic                 rm_hit;
	logic [TW-1:0]        rm_newc;
	logic [TW-1:0]        ri_pos;
	logic [TW-1:0]        sel_newc;
	logic                 dl_list;
	logic [TW-1:0]        hd;
	logic                 hd_ok;
	logic                 cur_ok;
	logic                 prev_nil;

	// The shared wake-time comparator: cmp_lt is cmp_a < cmp_b.
	logic [TICK_BITS-1:0] cmp_a, cmp_b;
	logic                 cmp_lt;

	always_comb begin
		case (state_q)
			ST_IDLE, ST_AFTER_DET: prio_ra = rt_q;
			ST_TK_HEAD:            prio_ra = hd[IW-1:0];
			default:               prio_ra = tgt_q;
		endcase
		case (state_q)
			ST_TK_HEAD: wl_ra = hd[IW-1:0];
			default:    wl_ra = cur_q[IW-1:0];
		endcase
		case (state_q)
			ST_DET, ST_RI: cnt_ra = prio_rd;
			ST_TK_END:     cnt_ra = rp_q;
			default:       cnt_ra = p_q;
		endcase
	end

	assign prio_rd = prio_q[prio_ra];
	assign wake_rd = wake_q[wl_ra];
	assign link_rd = link_q[wl_ra];
	assign cnt_rd  = cnt_q[cnt_ra];
	assign rcur_rd = rcur_q[cnt_ra];

	always_comb begin
		case (state_q)
			ST_DI_WALK: begin
				cmp_a = key_q;
				cmp_b = wake_rd;
			end
			ST_TK_HEAD: begin
				cmp_a = tick_q;
				cmp_b = wake_rd;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = tick_q;
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;

	assign tid_ok    = 32'(req.task_id) < 32'(NUM_TASKS);
	assign pclamp    = (32'(req.priority_req) >= 32'(NUM_PRIORITIES)) ?
		PW'(NUM_PRIORITIES - 1) : PW'(req.priority_req);
	assign tick_inc  = tick_q + TICK_BITS'(1);
	assign det_place = place_q[tgt_q];
	assign rm_hit    = seq_rd_q == tgt_q;
	assign dl_list   = cmp_lt ? ~act_q : act_q;
	assign hd        = head_q[act_q];
	assign hd_ok     = hd < NIL;
	assign cur_ok    = cur_q < NIL;
	assign prev_nil  = prev_q == NIL;

	// Cursor after removing the entry at i_q.
	always_comb begin
		if (c_q == i_q) begin
			rm_newc = (i_q == '0) ? NIL : i_q - TW'(1);
		end else if (c_q != NIL && c_q > i_q) begin
			rm_newc = c_q - TW'(1);
		end else begin
			rm_newc = c_q;
		end
	end

	// A new ready task goes in just ahead of the cursor entry, or at the end.
	assign ri_pos   = (rcur_rd == NIL || rcur_rd >= cnt_rd) ? cnt_rd : rcur_rd;
	assign sel_newc = (rcur_rd == NIL || (rcur_rd + TW'(1)) >= cnt_rd) ?
		'0 : rcur_rd + TW'(1);

	// Memory port control.
	always_comb begin
		mr_en  = 1'b0;
		mr_idx = i_q;
		mr_p   = p_q;
		mw_en  = 1'b0;
		mw_idx = k_q;
		mw_p   = p_q;
		mw_d   = seq_rd_q;
		case (state_q)
			ST_RM_RD: mr_en = i_q < n_q;
			ST_RM_SH_RD: begin
				mr_en  = 1'b1;
				mr_idx = k_q + TW'(1);
			end
			ST_RI_SH_RD: begin
				mr_en  = 1'b1;
				mr_idx = k_q - TW'(1);
			end
			ST_SEL_SCAN: begin
				mr_en  = cnt_rd != '0;
				mr_idx = sel_newc;
			end
			ST_RM_SH_WR, ST_RI_SH_WR: mw_en = 1'b1;
			ST_RI_PUT: begin
				mw_en  = 1'b1;
				mw_idx = i_q;
				mw_d   = tgt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mw_en) begin
			seq_mem[mw_p][mw_idx[IW-1:0]] <= mw_d;
		end
		if (mr_en) begin
			seq_rd_q <= seq_mem[mr_p][mr_idx[IW-1:0]];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_code_t'(req.req_type))
						REQ_CREATE: state_d = tid_ok ? ST_DET : ST_DONE;
						REQ_DELAY:  state_d = (req.delay_ticks != '0 && rv_q) ?
							ST_DET : ST_SEL_INIT;
						REQ_TICK:   state_d = ST_TK_HEAD;
						REQ_SWITCH: state_d = ST_SEL_INIT;
					endcase
				end
			end
			ST_DET: begin
				if (det_place == PLACE_READY) begin
					state_d = ST_RM_RD;
				end else if (det_place[1]) begin
					state_d = ST_DR_WALK;
				end else begin
					state_d = ST_AFTER_DET;
				end
			end
			ST_RM_RD:    state_d = (i_q >= n_q) ? ST_AFTER_DET : ST_RM_CMP;
			ST_RM_CMP: begin
				if (!rm_hit) begin
					state_d = ST_RM_RD;
				end else if ((i_q + TW'(1)) < n_q) begin
					state_d = ST_RM_SH_RD;
				end else begin
					state_d = ST_AFTER_DET;
				end
			end
			ST_RM_SH_RD: state_d = ST_RM_SH_WR;
			ST_RM_SH_WR: state_d = (({1'b0, k_q} + (TW+1)'(2)) < {1'b0, n_q}) ?
				ST_RM_SH_RD : ST_AFTER_DET;
			ST_DR_WALK: begin
				if (cur_q == TW'(tgt_q) || !cur_ok) begin
					state_d = ST_AFTER_DET;
				end
			end
			ST_AFTER_DET: state_d = (req_q == REQ_CREATE) ? ST_RI : ST_DI_WALK;
			ST_DI_WALK: begin
				if (!(cur_ok && !cmp_lt)) begin
					state_d = ST_DI_LINK;
				end
			end
			ST_DI_LINK:  state_d = ST_SEL_INIT;
			ST_RI:       state_d = (cnt_rd > ri_pos) ? ST_RI_SH_RD : ST_RI_PUT;
			ST_RI_SH_RD: state_d = ST_RI_SH_WR;
			ST_RI_SH_WR: state_d = ((k_q - TW'(1)) > i_q) ? ST_RI_SH_RD : ST_RI_PUT;
			ST_RI_PUT:   state_d = (req_q == REQ_TICK) ? ST_TK_HEAD : ST_DONE;
			ST_TK_HEAD: begin
				if (!hd_ok || cmp_lt) begin
					state_d = ST_TK_END;
				end else begin
					state_d = ST_RI;
				end
			end
			ST_TK_END:   state_d = ST_DONE;
			ST_SEL_INIT: state_d = ST_SEL_SCAN;
			ST_SEL_SCAN: begin
				if (cnt_rd != '0) begin
					state_d = ST_SEL_RD;
				end else if (p_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_SEL_RD:   state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
		endcase
	end

	// Control registers and the list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			req_q     <= REQ_CREATE;
			rt_q      <= '0;
			rv_q      <= 1'b0;
			top_q     <= '0;
			tick_q    <= '0;
			unblock_q <= '1;
			act_q     <= 1'b0;
			sw_q      <= 1'b0;
			head_q[0] <= NIL;
			head_q[1] <= NIL;
			for (int p = 0; p < NUM_PRIORITIES; p++) begin
				cnt_q[p]  <= '0;
				rcur_q[p] <= NIL;
			end
			for (int t = 0; t < NUM_TASKS; t++) begin
				place_q[t] <= PLACE_NONE;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req_code_t'(req.req_type);
						sw_q  <= 1'b0;
						if (req_code_t'(req.req_type) == REQ_TICK) begin
							tick_q    <= tick_inc;
							unblock_q <= '1;
							if (tick_inc == '0) begin
								act_q <= ~act_q;
							end
						end
					end
				end
				ST_DET: place_q[tgt_q] <= PLACE_NONE;
				ST_RM_CMP: begin
					if (rm_hit) begin
						rcur_q[p_q] <= rm_newc;
						cnt_q[p_q]  <= n_q - TW'(1);
					end
				end
				ST_DR_WALK: begin
					if (cur_q == TW'(tgt_q) && prev_nil) begin
						head_q[l_q] <= link_rd;
					end
				end
				ST_AFTER_DET: begin
					if (req_q == REQ_CREATE) begin
						if (!rv_q) begin
							rt_q <= tgt_q;
							rv_q <= 1'b1;
						end else if (rt_q != tgt_q && prio_rd < pnew_q) begin
							rt_q <= tgt_q;
						end
					end else if (!cmp_lt && key_q < unblock_q) begin
						unblock_q <= key_q;
					end
				end
				ST_DI_LINK: begin
					if (prev_nil) begin
						head_q[l_q] <= TW'(tgt_q);
					end
					place_q[tgt_q] <= {1'b1, l_q};
				end
				ST_RI: begin
					if (top_q < prio_rd) begin
						top_q <= prio_rd;
					end
					if (req_q == REQ_TICK && (!rv_q || prio_rd >= rp_q)) begin
						sw_q <= 1'b1;
					end
				end
				ST_RI_PUT: begin
					cnt_q[p_q] <= n_q + TW'(1);
					if (c_q != NIL && c_q < n_q) begin
						rcur_q[p_q] <= c_q + TW'(1);
					end
					place_q[tgt_q] <= PLACE_READY;
				end
				ST_TK_HEAD: begin
					if (hd_ok) begin
						if (cmp_lt) begin
							unblock_q <= wake_rd;
						end else begin
							head_q[act_q]       <= link_rd;
							place_q[hd[IW-1:0]] <= PLACE_NONE;
						end
					end
				end
				ST_TK_END: begin
					if (rv_q && cnt_rd > TW'(1)) begin
						sw_q <= 1'b1;
					end
				end
				ST_SEL_SCAN: begin
					if (cnt_rd != '0) begin
						rcur_q[p_q] <= sel_newc;
						top_q       <= p_q;
					end else if (p_q == '0) begin
						rv_q  <= 1'b0;
						rt_q  <= '0;
						top_q <= '0;
					end
				end
				ST_SEL_RD: begin
					rt_q <= seq_rd_q;
					rv_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Working registers and the per-task tables.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_code_t'(req.req_type))
						REQ_CREATE: begin
							tgt_q  <= IW'(req.task_id);
							pnew_q <= pclamp;
						end
						REQ_DELAY: begin
							tgt_q <= rt_q;
							key_q <= tick_q + TICK_BITS'(req.delay_ticks);
						end
						REQ_TICK:   rp_q <= prio_rd;
						REQ_SWITCH: ;
					endcase
				end
			end
			ST_DET: begin
				p_q    <= prio_rd;
				n_q    <= cnt_rd;
				c_q    <= rcur_rd;
				i_q    <= '0;
				l_q    <= det_place[0];
				cur_q  <= head_q[det_place[0]];
				prev_q <= NIL;
			end
			ST_RM_CMP: begin
				if (rm_hit) begin
					k_q <= i_q;
				end else begin
					i_q <= i_q + TW'(1);
				end
			end
			ST_RM_SH_WR: k_q <= k_q + TW'(1);
			ST_DR_WALK: begin
				if (cur_q == TW'(tgt_q)) begin
					if (!prev_nil) begin
						link_q[prev_q[IW-1:0]] <= link_rd;
					end
				end else if (cur_ok) begin
					prev_q <= cur_q;
					cur_q  <= link_rd;
				end
			end
			ST_AFTER_DET: begin
				if (req_q == REQ_CREATE) begin
					prio_q[tgt_q] <= pnew_q;
				end else begin
					wake_q[tgt_q] <= key_q;
					l_q           <= dl_list;
					cur_q         <= head_q[dl_list];
					prev_q        <= NIL;
				end
			end
			ST_DI_WALK: begin
				if (cur_ok && !cmp_lt) begin
					prev_q <= cur_q;
					cur_q  <= link_rd;
				end else begin
					link_q[tgt_q] <= cur_q;
				end
			end
			ST_DI_LINK: begin
				if (!prev_nil) begin
					link_q[prev_q[IW-1:0]] <= TW'(tgt_q);
				end
			end
			ST_RI: begin
				p_q <= prio_rd;
				n_q <= cnt_rd;
				c_q <= rcur_rd;
				i_q <= ri_pos;
				k_q <= cnt_rd;
			end
			ST_RI_SH_WR: k_q <= k_q - TW'(1);
			ST_TK_HEAD:  tgt_q <= hd[IW-1:0];
			ST_SEL_INIT: p_q <= top_q;
			ST_SEL_SCAN: begin
				if (cnt_rd == '0 && p_q != '0) begin
					p_q <= p_q - PW'(1);
				end
			end
			default: ;
		endcase
	end

	// Outputs: the result is shown for the single cycle spent in the done state.
	always_comb begin
		busy                   = state_q != ST_IDLE;
		done                   = state_q == ST_DONE;
		rsp.current_task       = rv_q ? 4'(rt_q) : 4'd0;
		rsp.no_ready_task      = ~rv_q;
		rsp.switch_request     = sw_q;
		rsp.next_unblock_time  = 32'(unblock_q);
		rsp.tick_now           = 32'(tick_q);
	end

endmodule

FILE: hdl/pts_checker.sv
// Port-level checks of the task scheduler, bound to its top level.
// Depends on pts_pkg and on priority_task_scheduler_with_delays_assert.svh.
`include "priority_task_scheduler_with_delays_assert.svh"

module pts_checker
	import pts_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input pts_rsp_t rsp
);

	// An accepted beat keeps the block busy in the next cycle.
	`PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

	// A result only appears while a beat is in progress.
	`PTS_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")

	// The result strobe lasts exactly one cycle.
	`PTS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

	// With nothing running the reported task slot reads zero.
	`PTS_ASSERT_NOW(a_empty_task, done && rsp.no_ready_task, rsp.current_task == 4'd0,
		"task slot reported while no task runs")

endmodule

bind priority_task_scheduler_with_delays pts_checker u_pts_checker (.*);

FILE: test/priority_task_scheduler_with_delays_tb.sv
// Self-checking testbench for the priority task scheduler: directed and random event beats.
// Depends on pts_pkg and the priority_task_scheduler_with_delays top level only.
module priority_task_scheduler_with_delays_tb;
	import pts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPRIO = PTS_NUM_PRIORITIES;
	localparam int NTASK = PTS_NUM_TASKS;
	localparam int NIL   = NTASK;
	localparam int N_RANDOM = 1430;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	pts_req_t req = '0;
	logic     done;
	pts_rsp_t rsp;

	priority_task_scheduler_with_delays uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	// Event beats waiting to be driven, and scheduler outputs still owed by the block.
	pts_req_t event_queue[$];
	pts_rsp_t owed_rsp[$];
	int       accepted_beats = 0;
	int       error_count = 0;

	// Shadow copy of the scheduler state, kept in step with every accepted beat.
	logic [2:0]  sh_prio[NTASK];
	logic [31:0] sh_wake[NTASK];
	logic [1:0]  sh_place[NTASK];
	int          sh_link[NTASK];
	int          sh_seq[NPRIO][NTASK];
	int          sh_count[NPRIO];
	int          sh_cursor[NPRIO];
	int          sh_dhead[2];
	int          sh_active;
	int          sh_top;
	logic [31:0] sh_tick;
	logic [31:0] sh_unblock;
	int          sh_run;
	bit          sh_run_valid;

	initial begin
		for (int i = 0; i < NTASK; i++) begin
			sh_prio[i] = '0;
			sh_wake[i] = '0;
			sh_place[i] = PLACE_NONE;
			sh_link[i] = 0;
		end
		for (int p = 0; p < NPRIO; p++) begin
			sh_count[p] = 0;
			sh_cursor[p] = NIL;
		end
		sh_dhead[0] = NIL;
		sh_dhead[1] = NIL;
		sh_active = 0;
		sh_top = 0;
		sh_tick = '0;
		sh_unblock = '1;
		sh_run = 0;
		sh_run_valid = 0;
	end

	// A ready task goes in just ahead of the cursor, so the round-robin order sees it last.
	function automatic void ready_file(int t);
		int p, n, c, pos;
		p = sh_prio[t];
		n = sh_count[p];
		c = sh_cursor[p];
		if (n >= NTASK)
			return;
		if (sh_top < p)
			sh_top = p;
		pos = (c == NIL || c >= n) ? n : c;
		for (int k = n; k > pos; k--)
			sh_seq[p][k] = sh_seq[p][k - 1];
		sh_seq[p][pos] = t;
		sh_count[p] = n + 1;
		if (c != NIL && c < n)
			sh_cursor[p] = c + 1;
		sh_place[t] = PLACE_READY;
	endfunction

	function automatic void ready_unfile(int t);
		int p, n, c, i;
		p = sh_prio[t];
		n = sh_count[p];
		c = sh_cursor[p];
		i = 0;
		while (i < n && sh_seq[p][i] != t)
			i++;
		if (i >= n)
			return;
		if (c == i)
			c = (i == 0) ? NIL : i - 1;
		else if (c != NIL && c > i)
			c--;
		for (int k = i; k + 1 < n; k++)
			sh_seq[p][k] = sh_seq[p][k + 1];
		sh_count[p] = n - 1;
		sh_cursor[p] = c;
	endfunction

	// Delay lists are singly linked and sorted by wake time; equal times keep arrival order.
	function automatic void sleep_file(int t, int l);
		int prev, cur, guard;
		prev = NIL;
		cur = sh_dhead[l];
		guard = 0;
		while (cur < NTASK && sh_wake[cur] <= sh_wake[t] && guard < NTASK) begin
			prev = cur;
			cur = sh_link[cur];
			guard++;
		end
		sh_link[t] = (cur < NTASK) ? cur : NIL;
		if (prev == NIL)
			sh_dhead[l] = t;
		else
			sh_link[prev] = t;
		sh_place[t] = 2'(PLACE_DELAY0 + l);
	endfunction

	function automatic void sleep_unfile(int t, int l);
		int prev, cur, guard;
		prev = NIL;
		cur = sh_dhead[l];
		guard = 0;
		while (cur < NTASK && cur != t && guard < NTASK) begin
			prev = cur;
			cur = sh_link[cur];
			guard++;
		end
		if (cur != t)
			return;
		if (prev == NIL)
			sh_dhead[l] = sh_link[t];
		else
			sh_link[prev] = sh_link[t];
	endfunction

	function automatic void unlist(int t);
		if (sh_place[t] == PLACE_READY)
			ready_unfile(t);
		else if (sh_place[t] >= PLACE_DELAY0)
			sleep_unfile(t, sh_place[t][0]);
		sh_place[t] = PLACE_NONE;
	endfunction

	// Pick the next task round-robin at the highest priority that has a ready task.
	function automatic void pick_next();
		int p, c;
		p = (sh_top < NPRIO) ? sh_top : NPRIO - 1;
		while (sh_count[p] == 0) begin
			if (p == 0) begin
				sh_run_valid = 0;
				sh_run = 0;
				sh_top = 0;
				return;
			end
			p--;
		end
		c = sh_cursor[p];
		if (c == NIL || c + 1 >= sh_count[p])
			c = 0;
		else
			c++;
		sh_cursor[p] = c;
		sh_run = sh_seq[p][c];
		sh_run_valid = 1;
		sh_top = p;
	endfunction

	// Applies one event to the shadow state and returns what the block must report.
	function automatic pts_rsp_t schedule_event(pts_req_t ev);
		pts_rsp_t r;
		bit sw;
		int t, p, l, h;
		logic [32:0] wsum;
		logic [31:0] w;
		sw = 0;
		case (req_code_t'(ev.req_type))
			REQ_CREATE: begin
				t = ev.task_id;
				if (t < NTASK) begin
					// Priorities above the top level are clamped to it.
					p = (ev.priority_req >= NPRIO) ? NPRIO - 1 : ev.priority_req;
					unlist(t);
					sh_prio[t] = 3'(p);
					if (!sh_run_valid) begin
						sh_run = t;
						sh_run_valid = 1;
					end else if (sh_prio[sh_run] < p) begin
						sh_run = t;
					end
					ready_file(t);
				end
			end
			REQ_DELAY: begin
				if (ev.delay_ticks != 0 && sh_run_valid) begin
					t = sh_run;
					wsum = {1'b0, sh_tick} + {1'b0, ev.delay_ticks};
					w = wsum[31:0];
					unlist(t);
					sh_wake[t] = w;
					// A wake time past the wrap goes to the other list.
					if (w >= sh_tick) begin
						sleep_file(t, sh_active);
						if (w < sh_unblock)
							sh_unblock = w;
					end else begin
						sleep_file(t, sh_active ^ 1);
					end
				end
				pick_next();
			end
			REQ_TICK: begin
				sh_tick = sh_tick + 32'd1;
				if (sh_tick == 0)
					sh_active ^= 1;
				l = sh_active;
				sh_unblock = '1;
				while (sh_dhead[l] < NTASK) begin
					h = sh_dhead[l];
					if (sh_wake[h] > sh_tick) begin
						sh_unblock = sh_wake[h];
						break;
					end
					sh_dhead[l] = sh_link[h];
					sh_place[h] = PLACE_NONE;
					ready_file(h);
					if (!sh_run_valid || sh_prio[h] >= sh_prio[sh_run])
						sw = 1;
				end
				if (sh_run_valid && sh_count[sh_prio[sh_run]] > 1)
					sw = 1;
			end
			default: pick_next();
		endcase
		r.current_task = sh_run_valid ? sh_run[3:0] : 4'd0;
		r.no_ready_task = !sh_run_valid;
		r.switch_request = sw;
		r.next_unblock_time = sh_unblock;
		r.tick_now = sh_tick;
		return r;
	endfunction

	// 12 ns clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// The sender's idle rate follows the phase of the run: 19 in a hundred for the first 480
	// accepted beats, 60 for the next 480, and never after that.
	function automatic bit sender_idles();
		if (accepted_beats < 480)
			return $urandom_range(0, 99) < 19;
		if (accepted_beats < 960)
			return $urandom_range(0, 99) < 60;
		return 0;
	endfunction

	// Driver. A beat is accepted at an edge where start is high and busy is low; the
	// prediction is taken right there, from the value still on req. start is written
	// once per edge, so a beat that follows another keeps start high without a glitch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				owed_rsp.push_back(schedule_event(req));
				accepted_beats++;
			end
			if (!start || !busy) begin
				if (event_queue.size() > 0 && !sender_idles()) begin
					req <= event_queue.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
			error_count++;
		end
	endtask

	// Monitor. The strobe cannot be held off, so each done cycle is one result beat.
	always @(posedge clk) begin
		pts_rsp_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (owed_rsp.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, got %h", $time, rsp);
				error_count++;
			end else begin
				exp_r = owed_rsp.pop_front();
				compare_field("current_task", exp_r.current_task, rsp.current_task);
				compare_field("no_ready_task", exp_r.no_ready_task, rsp.no_ready_task);
				compare_field("switch_request", exp_r.switch_request, rsp.switch_request);
				compare_field("next_unblock_time", exp_r.next_unblock_time,
					rsp.next_unblock_time);
				compare_field("tick_now", exp_r.tick_now, rsp.tick_now);
			end
		end
	end

	function automatic pts_req_t make_event(req_code_t code, int tid, int prio, logic [31:0] dly);
		pts_req_t e;
		e.req_type = code;
		e.task_id = 4'(tid);
		e.priority_req = 8'(prio);
		e.delay_ticks = dly;
		return e;
	endfunction

	// Random events lean toward sequences that keep tasks moving between the lists: creates
	// feed the ready lists, short delays the delay lists, ticks wake them, switches rotate.
	function automatic pts_req_t random_event();
		int pick;
		int prio;
		logic [31:0] dly;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
			return make_event(REQ_CREATE, $urandom_range(0, 15), prio, $urandom);
		end
		if (pick < 50) begin
			case ($urandom_range(0, 9))
				0: dly = 32'd0;
				1: dly = $urandom;
				2: dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
				default: dly = $urandom_range(1, 6);
			endcase
			return make_event(REQ_DELAY, $urandom_range(0, 15), $urandom_range(0, 255), dly);
		end
		if (pick < 85)
			return make_event(REQ_TICK, $urandom_range(0, 15), $urandom_range(0, 255), $urandom);
		return make_event(REQ_SWITCH, $urandom_range(0, 15), $urandom_range(0, 255), $urandom);
	endfunction

	initial begin
		// Directed part. The empty scheduler comes first: delay with no running task,
		// a switch and a tick with nothing ready.
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd5));
		event_queue.push_back(make_event(REQ_SWITCH, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		// Creates at the priority extremes, with clamping of large requests.
		event_queue.push_back(make_event(REQ_CREATE, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_CREATE, 15, 255, 32'd0));
		event_queue.push_back(make_event(REQ_CREATE, 7, 8, 32'd0));
		event_queue.push_back(make_event(REQ_CREATE, 3, 7, 32'd0));
		event_queue.push_back(make_event(REQ_SWITCH, 0, 0, 32'd0));
		// Re-creating a task that is already in a ready list, at a new priority.
		event_queue.push_back(make_event(REQ_CREATE, 3, 2, 32'd0));
		// Delay of zero only rotates; then short delays and one past the tick wrap.
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd2));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd1));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'hFFFF_FFFF));
		// Re-creating a delayed task pulls it out of its delay list; the next tick
		// recomputes the stale unblock time.
		event_queue.push_back(make_event(REQ_CREATE, 15, 1, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		// Drain the ready set until nothing is runnable, then let a tick wake a task.
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd3));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd3));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd3));
		event_queue.push_back(make_event(REQ_DELAY, 0, 0, 32'd3));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		event_queue.push_back(make_event(REQ_TICK, 0, 0, 32'd0));
		for (int i = 0; i < N_RANDOM; i++)
			event_queue.push_back(random_event());

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (event_queue.size() > 0 || start)
			@(posedge clk);
		while (owed_rsp.size() > 0)
			@(posedge clk);
		// Room for any stray result beat after the last expected one.
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of these beats.
	initial begin
		#60_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pts_pkg.sv
hdl/priority_task_scheduler_with_delays.sv
hdl/pts_checker.sv
test/priority_task_scheduler_with_delays_tb.sv
